/* hw/rtl/fscw_pkg.sv */
// Shared types and constants for the Feistel S-box cycle-walk block.
package fscw_pkg;

  localparam int WORD_W   = 64;
  localparam int HALF_W   = 32;
  localparam int MAX_WALK = 64;
  localparam int PASS_W   = $clog2(MAX_WALK + 1);
  localparam int CNT_W    = $clog2(WORD_W);
  localparam int IDX_W    = 3;
  localparam int EXPF_W   = 7;

  localparam logic [WORD_W-1:0] MODULUS_RST     = '1;
  localparam logic [HALF_W-1:0] ROUND_PRIME_RST = 32'd4294967291;

  typedef enum logic [IDX_W-1:0] {
    REG_MODULUS     = 3'd0,
    REG_ROUND_PRIME = 3'd1,
    REG_KEY_FIRST   = 3'd2,
    REG_KEY_SECOND  = 3'd3,
    REG_MODE        = 3'd4,
    REG_EXP_FWD     = 3'd5,
    REG_EXP_INV     = 3'd6
  } reg_idx_t;

  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_FMUL,
    CMD_RED,
    CMD_ROUND,
    CMD_PSETUP,
    CMD_MSTART_ACC,
    CMD_MSTART_SQ,
    CMD_MDBL,
    CMD_MADD,
    CMD_MSTORE,
    CMD_FINISH
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_F_MUL,
    ST_F_RED,
    ST_F_ROUND,
    ST_F_CHECK,
    ST_P_RED,
    ST_P_SETUP,
    ST_P_CHECK,
    ST_M_SQ,
    ST_M_DBL,
    ST_M_ADD,
    ST_M_STORE,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic feistel;
    logic cnt_zero;
    logic rnd;
    logic walk_end;
    logic exp_zero;
    logic exp_lsb;
    logic sel;
    logic out_busy;
  } status_t;

endpackage

/* hw/rtl/fscw_ctrl.sv */
// Sequencer for Feistel passes, modular reduction and square-and-multiply.
module fscw_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  fscw_pkg::status_t status,
  output fscw_pkg::cmd_t    cmd
);
  import fscw_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (in_valid) state_next = ST_LOAD;
      ST_LOAD:    state_next = status.feistel ? ST_F_MUL : ST_P_RED;
      ST_F_MUL:   state_next = ST_F_RED;
      ST_F_RED:   if (status.cnt_zero) state_next = ST_F_ROUND;
      ST_F_ROUND: state_next = status.rnd ? ST_F_CHECK : ST_F_MUL;
      ST_F_CHECK: state_next = status.walk_end ? ST_FIN : ST_F_MUL;
      ST_P_RED:   if (status.cnt_zero) state_next = ST_P_SETUP;
      ST_P_SETUP: state_next = ST_P_CHECK;
      ST_P_CHECK: state_next = status.exp_zero ? ST_FIN : ST_M_DBL;
      ST_M_SQ:    state_next = ST_M_DBL;
      ST_M_DBL:   state_next = ST_M_ADD;
      ST_M_ADD:   state_next = status.cnt_zero ? ST_M_STORE : ST_M_DBL;
      ST_M_STORE: state_next = status.sel ? ST_P_CHECK : ST_M_SQ;
      ST_FIN:     if (!status.out_busy) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = CMD_NOP;
    in_ready = 1'b0;
    case (state)
      ST_IDLE:    in_ready = 1'b1;
      ST_LOAD:    cmd = CMD_NOP;
      ST_F_MUL:   cmd = CMD_FMUL;
      ST_F_RED:   cmd = CMD_RED;
      ST_F_ROUND: cmd = CMD_ROUND;
      ST_F_CHECK: cmd = CMD_NOP;
      ST_P_RED:   cmd = CMD_RED;
      ST_P_SETUP: cmd = CMD_PSETUP;
      ST_P_CHECK: begin
        if (!status.exp_zero) begin
          cmd = status.exp_lsb ? CMD_MSTART_ACC : CMD_MSTART_SQ;
        end
      end
      ST_M_SQ:    cmd = CMD_MSTART_SQ;
      ST_M_DBL:   cmd = CMD_MDBL;
      ST_M_ADD:   cmd = CMD_MADD;
      ST_M_STORE: cmd = CMD_MSTORE;
      ST_FIN:     if (!status.out_busy) cmd = CMD_FINISH;
      default:    cmd = CMD_NOP;
    endcase
    if (state == ST_IDLE && in_valid) cmd = CMD_LOAD;
  end

endmodule

/* hw/rtl/fscw_dp.sv */
// Datapath: config registers, round multiplier, bit-serial reducer and mulmod, output word.
module fscw_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [fscw_pkg::IDX_W-1:0]  cfg_index,
  input  logic [fscw_pkg::WORD_W-1:0] cfg_data,
  input  logic                        in_operation,
  input  logic [fscw_pkg::WORD_W-1:0] in_value,
  input  fscw_pkg::cmd_t              cmd,
  output fscw_pkg::status_t           status,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [fscw_pkg::WORD_W-1:0] out_result,
  output logic                        out_overflow
);
  import fscw_pkg::*;

  logic [WORD_W-1:0] modulus;
  logic [HALF_W-1:0] round_prime;
  logic [HALF_W-1:0] key_first;
  logic [HALF_W-1:0] key_second;
  logic              feistel_mode;
  logic [EXPF_W-1:0] exp_fwd;
  logic [WORD_W-1:0] exp_inv;

  logic              op;
  logic              rnd;
  logic [PASS_W-1:0] passes;
  logic [WORD_W-1:0] x;
  logic [WORD_W-1:0] prod;
  logic [WORD_W-1:0] rem;
  logic [CNT_W-1:0]  cnt;
  logic [WORD_W-1:0] acc;
  logic [WORD_W-1:0] base;
  logic [WORD_W-1:0] expo;
  logic              sel;
  logic [WORD_W-1:0] ma;
  logic [WORD_W-1:0] mb;
  logic [WORD_W-1:0] macc;

  logic [HALF_W-1:0] src;
  logic [HALF_W-1:0] key;
  logic [HALF_W-1:0] t;
  logic [WORD_W-1:0] red_m;
  logic [WORD_W:0]   rem_sh;
  logic [WORD_W:0]   rem_sub;
  logic [WORD_W-1:0] rem_next;
  logic              x_lt_m;

  function automatic logic [WORD_W-1:0] add_mod(input logic [WORD_W-1:0] a,
                                                input logic [WORD_W-1:0] b,
                                                input logic [WORD_W-1:0] m);
    logic [WORD_W-1:0] room;
    room = m - b;
    return (a >= room) ? (a - room) : (a + b);
  endfunction

  assign src     = op ? x[WORD_W-1:HALF_W] : x[HALF_W-1:0];
  assign key     = (rnd ^ op) ? key_second : key_first;
  assign t       = (round_prime == '0) ? '0 : rem[HALF_W-1:0];
  assign red_m   = feistel_mode ? {{(WORD_W-HALF_W){1'b0}}, round_prime} : modulus;
  assign rem_sh  = {rem, prod[WORD_W-1]};
  assign rem_sub = rem_sh - {1'b0, red_m};
  assign rem_next = (rem_sh >= {1'b0, red_m}) ? rem_sub[WORD_W-1:0] : rem_sh[WORD_W-1:0];
  assign x_lt_m  = x < modulus;

  assign status.feistel  = feistel_mode;
  assign status.cnt_zero = (cnt == '0);
  assign status.rnd      = rnd;
  assign status.walk_end = x_lt_m || (passes == PASS_W'(MAX_WALK));
  assign status.exp_zero = (expo == '0);
  assign status.exp_lsb  = expo[0];
  assign status.sel      = sel;
  assign status.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus      <= MODULUS_RST;
      round_prime  <= ROUND_PRIME_RST;
      key_first    <= HALF_W'(1);
      key_second   <= HALF_W'(1);
      feistel_mode <= 1'b1;
      exp_fwd      <= EXPF_W'(1);
      exp_inv      <= WORD_W'(1);
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MODULUS:     modulus      <= cfg_data;
          REG_ROUND_PRIME: round_prime  <= cfg_data[HALF_W-1:0];
          REG_KEY_FIRST:   key_first    <= cfg_data[HALF_W-1:0];
          REG_KEY_SECOND:  key_second   <= cfg_data[HALF_W-1:0];
          REG_MODE:        feistel_mode <= cfg_data[0];
          REG_EXP_FWD:     exp_fwd      <= cfg_data[EXPF_W-1:0];
          REG_EXP_INV:     exp_inv      <= cfg_data;
          default:         ;
        endcase
      end
      if (cmd == CMD_FINISH) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        x      <= in_value;
        op     <= in_operation;
        rnd    <= 1'b0;
        passes <= '0;
        prod   <= in_value;
        rem    <= '0;
        cnt    <= '1;
      end
      CMD_FMUL: begin
        prod <= {{(WORD_W-HALF_W){1'b0}}, src} * {{(WORD_W-HALF_W){1'b0}}, key};
        rem  <= '0;
        cnt  <= '1;
      end
      CMD_RED: begin
        rem  <= rem_next;
        prod <= {prod[WORD_W-2:0], 1'b0};
        cnt  <= cnt - CNT_W'(1);
      end
      CMD_ROUND: begin
        x   <= op ? {x[HALF_W-1:0] ^ t, x[WORD_W-1:HALF_W]}
                  : {x[HALF_W-1:0], x[WORD_W-1:HALF_W] ^ t};
        rnd <= ~rnd;
        if (rnd) passes <= passes + PASS_W'(1);
      end
      CMD_PSETUP: begin
        base <= (modulus == '0) ? '0 : rem;
        acc  <= (modulus <= WORD_W'(1)) ? '0 : WORD_W'(1);
        expo <= op ? exp_inv : {{(WORD_W-EXPF_W){1'b0}}, exp_fwd};
      end
      CMD_MSTART_ACC: begin
        sel  <= 1'b0;
        ma   <= base;
        mb   <= acc;
        macc <= '0;
        cnt  <= '1;
      end
      CMD_MSTART_SQ: begin
        sel  <= 1'b1;
        ma   <= base;
        mb   <= base;
        macc <= '0;
        cnt  <= '1;
      end
      CMD_MDBL: macc <= add_mod(macc, macc, modulus);
      CMD_MADD: begin
        if (mb[WORD_W-1]) macc <= add_mod(macc, ma, modulus);
        mb  <= {mb[WORD_W-2:0], 1'b0};
        cnt <= cnt - CNT_W'(1);
      end
      CMD_MSTORE: begin
        if (sel) begin
          base <= macc;
          expo <= expo >> 1;
        end else begin
          acc <= macc;
        end
      end
      CMD_FINISH: begin
        out_result   <= feistel_mode ? x : ((modulus == '0) ? '0 : acc);
        out_overflow <= feistel_mode && !x_lt_m;
      end
      default: ;
    endcase
  end

endmodule

/* hw/rtl/feistel_sbox_cycle_walk.sv */
// Top level: Feistel S-box with cycle walking and modular power fallback.
// Feistel mode: each pass is two rounds (multiply, 64-step serial reduction, xor) and a
//   limit check; one pass usually, up to 64.
// Power mode: load and reduction, then per exponent bit a square, after a multiply if the bit is set.
// One word at a time; the next word is taken while a finished result waits at the output.
// Synchronous active-high rst restores the register reset values and empties the output.
module feistel_sbox_cycle_walk (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [fscw_pkg::IDX_W-1:0]  cfg_index,
  input  logic [fscw_pkg::WORD_W-1:0] cfg_data,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [fscw_pkg::WORD_W-1:0] s_tdata,   // [63:0] value
  input  logic                        s_tuser,   // [0] operation
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [fscw_pkg::WORD_W-1:0] m_tdata,   // [63:0] result
  output logic                        m_tuser    // [0] walk_overflow
);
  import fscw_pkg::*;

  cmd_t    cmd;
  status_t status;

  fscw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  fscw_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_operation (s_tuser),
    .in_value     (s_tdata),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_result   (m_tdata),
    .out_overflow (m_tuser)
  );

endmodule

/* hw/rtl/fscw_checker.sv */
// Port-level checks for the Feistel S-box block, bound to the top level.
module fscw_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [fscw_pkg::WORD_W-1:0] m_tdata,
  input logic                        m_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while a word is in work");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule

bind feistel_sbox_cycle_walk fscw_checker u_fscw_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

/* tb/feistel_sbox_cycle_walk_tb.sv */
// Testbench for feistel_sbox_cycle_walk: directed and random words checked against a predictor.
`timescale 1ns / 100ps

module feistel_sbox_cycle_walk_tb;
  import fscw_pkg::*;

  localparam int LIMIT_CYCLES = 20_000_000;

  typedef struct {
    logic        op;
    logic [63:0] val;
  } sbox_in_t;

  typedef struct {
    logic [63:0] res;
    logic        ovf;
  } sbox_out_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [IDX_W-1:0]    cfg_index = REG_MODULUS;
  logic [WORD_W-1:0]   cfg_data = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [WORD_W-1:0]   s_tdata = '0;
  logic                s_tuser = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [WORD_W-1:0]   m_tdata;
  logic                m_tuser;

  // mirror of the block's registers
  logic [63:0] mod_p;
  logic [31:0] rprime, key1, key2;
  logic        fmode;
  logic [6:0]  exp_f;
  logic [63:0] exp_i;

  sbox_in_t  pending_words[$];
  sbox_out_t expected_images[$];
  int unsigned sent = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;

  feistel_sbox_cycle_walk DUT (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [31:0] round_mix(logic [31:0] h, logic [31:0] k);
    if (rprime == 32'd0) return 32'd0;
    return 32'(({32'd0, h} * {32'd0, k}) % {32'd0, rprime});
  endfunction

  function automatic logic [63:0] feistel_pass(logic inv, logic [63:0] x);
    logic [31:0] hi, lo, a, b;
    hi = x[63:32];
    lo = x[31:0];
    if (!inv) begin
      a = hi ^ round_mix(lo, key1);
      b = lo ^ round_mix(a, key2);
    end else begin
      b = lo ^ round_mix(hi, key2);
      a = hi ^ round_mix(b, key1);
    end
    return {a, b};
  endfunction

  function automatic logic [63:0] power_mod(logic [63:0] base, logic [63:0] e, logic [63:0] m);
    logic [127:0] acc, b;
    if (m == 64'd0) return 64'd0;
    b = base % m;
    acc = 128'd1 % m;
    while (e != 64'd0) begin
      if (e[0]) acc = (acc * b) % m;
      b = (b * b) % m;
      e = e >> 1;
    end
    return acc[63:0];
  endfunction

  function automatic sbox_out_t sbox_image(logic op, logic [63:0] v);
    sbox_out_t o;
    int passes;
    o.ovf = 1'b0;
    if (fmode) begin
      o.res = v;
      passes = 0;
      do begin
        o.res = feistel_pass(op, o.res);
        passes++;
      end while (o.res >= mod_p && passes < MAX_WALK);
      o.ovf = (o.res >= mod_p);
    end else begin
      o.res = power_mod(v, op ? exp_i : {57'd0, exp_f}, mod_p);
    end
    return o;
  endfunction

  // driver
  always @(posedge clk) begin
    int gap_pct;
    sbox_in_t w;
    gap_pct = (sent < 333) ? 29 : (sent < 666) ? 68 : 0;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!(s_tvalid && !s_tready)) begin
      if (s_tvalid) begin
        expected_images.push_back(sbox_image(s_tuser, s_tdata));
        sent++;
      end
      if (pending_words.size() > 0 && $urandom_range(0, 99) >= gap_pct) begin
        w = pending_words.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= w.op;
        s_tdata  <= w.val;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    int stall_pct;
    sbox_out_t e;
    stall_pct = (sent < 333) ? 68 : (sent < 666) ? 29 : 0;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_images.size() == 0) begin
          $error("unexpected word: result=%h walk_overflow=%b", m_tdata, m_tuser);
          errors++;
        end else begin
          e = expected_images.pop_front();
          if (m_tdata !== e.res) begin
            $error("result: expected %h, got %h", e.res, m_tdata);
            errors++;
          end
          if (m_tuser !== e.ovf) begin
            $error("walk_overflow: expected %b, got %b", e.ovf, m_tuser);
            errors++;
          end
        end
      end
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("feistel_sbox_cycle_walk_tb: done, errors");
      $finish;
    end
  end

  task automatic cfg_write(reg_idx_t idx, logic [63:0] d);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MODULUS:     mod_p  = d;
      REG_ROUND_PRIME: rprime = d[31:0];
      REG_KEY_FIRST:   key1   = d[31:0];
      REG_KEY_SECOND:  key2   = d[31:0];
      REG_MODE:        fmode  = d[0];
      REG_EXP_FWD:     exp_f  = d[6:0];
      REG_EXP_INV:     exp_i  = d;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || expected_images.size() > 0 || s_tvalid)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    case ($urandom_range(0, 9))
      0: return '1;
      1: return '0;
      2: return {32'd0, $urandom()};
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  task automatic queue_word(logic op, logic [63:0] v);
    sbox_in_t w;
    w.op = op;
    w.val = v;
    pending_words.push_back(w);
  endtask

  task automatic queue_random(int n);
    repeat (n) queue_word(1'($urandom_range(0, 1)), rand64());
  endtask

  task automatic random_keys();
    cfg_write(REG_ROUND_PRIME, {$urandom(), $urandom() | 32'h8000_0001});
    cfg_write(REG_KEY_FIRST, {$urandom(), $urandom()});
    cfg_write(REG_KEY_SECOND, {$urandom(), $urandom()});
  endtask

  initial begin
    mod_p  = MODULUS_RST;
    rprime = ROUND_PRIME_RST;
    key1   = 32'd1;
    key2   = 32'd1;
    fmode  = 1'b1;
    exp_f  = 7'd1;
    exp_i  = 64'd1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset settings, field extremes
    for (int op = 0; op < 2; op++) begin
      queue_word(1'(op), 64'd0);
      queue_word(1'(op), '1);
      queue_word(1'(op), 64'h5555_5555_5555_5555);
      queue_word(1'(op), 64'hAAAA_AAAA_AAAA_AAAA);
      queue_word(1'(op), 64'h0000_0000_FFFF_FFFF);
    end
    drain();

    // random keys, large modulus
    random_keys();
    cfg_write(REG_MODULUS, {1'b1, 31'($urandom_range(0, 32'h7FFF_FFFF)), $urandom()});
    queue_random(250);
    drain();

    // modulus between 2^62 and 2^63: frequent walking
    random_keys();
    cfg_write(REG_MODULUS, {2'b10, 30'($urandom()), $urandom()} >> 1);
    queue_random(200);
    drain();

    // degenerate round primes
    cfg_write(REG_MODULUS, '1);
    cfg_write(REG_ROUND_PRIME, 64'd0);
    queue_word(1'b0, 64'h1234_5678_9ABC_DEF0);
    queue_word(1'b1, '1);
    queue_word(1'b0, rand64());
    drain();
    cfg_write(REG_ROUND_PRIME, 64'd1);
    queue_random(4);
    drain();

    // all-ones keys and prime
    cfg_write(REG_ROUND_PRIME, {32'd0, 32'hFFFF_FFFF});
    cfg_write(REG_KEY_FIRST, '1);
    cfg_write(REG_KEY_SECOND, '1);
    queue_random(50);
    drain();

    // walk limit: modulus zero, then two
    random_keys();
    cfg_write(REG_MODULUS, 64'd0);
    queue_word(1'b0, rand64());
    queue_word(1'b1, rand64());
    drain();
    cfg_write(REG_MODULUS, 64'd2);
    queue_random(3);
    drain();

    // power fallback
    cfg_write(REG_MODE, 64'd0);
    cfg_write(REG_MODULUS, 64'd0);
    queue_word(1'b0, rand64());
    queue_word(1'b1, rand64());
    drain();
    cfg_write(REG_MODULUS, 64'd1);
    queue_word(1'b0, rand64());
    queue_word(1'b1, rand64());
    drain();
    cfg_write(REG_MODULUS, '1);
    cfg_write(REG_EXP_FWD, 64'd0);
    cfg_write(REG_EXP_INV, 64'd0);
    queue_word(1'b0, rand64());
    queue_word(1'b1, rand64());
    drain();
    cfg_write(REG_EXP_FWD, 64'h7F);
    cfg_write(REG_EXP_INV, '1);
    queue_word(1'b0, '1);
    queue_word(1'b1, 64'd12345);
    drain();
    cfg_write(REG_EXP_INV, {$urandom(), $urandom()});
    queue_word(1'b1, rand64());
    queue_word(1'b1, rand64());
    drain();
    for (int k = 0; k < 5; k++) begin
      cfg_write(REG_MODULUS, (k == 2) ? 64'($urandom_range(2, 1000)) : rand64() | 64'd2);
      cfg_write(REG_EXP_FWD, 64'($urandom_range(1, 127)));
      cfg_write(REG_EXP_INV, 64'($urandom_range(1, 65535)) >> $urandom_range(0, 15));
      queue_random(30);
      drain();
    end

    // back to Feistel mode
    cfg_write(REG_MODE, 64'd1);
    random_keys();
    cfg_write(REG_MODULUS, {1'b1, 31'($urandom()), $urandom()});
    queue_random(300);
    drain();

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("feistel_sbox_cycle_walk_tb: done, clean");
    end else begin
      $display("feistel_sbox_cycle_walk_tb: done, errors");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/fscw_pkg.sv
hw/rtl/fscw_ctrl.sv
hw/rtl/fscw_dp.sv
hw/rtl/feistel_sbox_cycle_walk.sv
hw/rtl/fscw_checker.sv
tb/feistel_sbox_cycle_walk_tb.sv
